>>> rtl/wms_pkg.sv
// shared types and constants for the weighted mean / sd / se block
package wms_pkg;

  localparam int SW_W = 20;   // weight sum
  localparam int SV_W = 37;   // weighted value sum, signed
  localparam int SQ_W = 52;   // weighted square sum
  localparam int N_W  = 72;   // numerator Sw*Swvv - Swv^2
  localparam int D_W  = 48;   // denominators Sw^2 and Sw^2*count
  localparam int Q_W  = 32;   // variance quotient
  localparam int WV_W = 28;   // one weight * value product, signed
  localparam int VV_W = 31;   // one value square
  localparam int MB_W = 37;   // multiplier operand b
  localparam int DC_W = 6;    // divider step counter

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic [11:0]        sample_weight;
    logic               value_missing;
    logic               last_item;
  } sample_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_ZERO_W = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [15:0] weighted_mean;
    logic [15:0]        weighted_sd;
    logic [15:0]        standard_error;
    status_t            result_status;
  } result_t;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_ACC  = 2'd1,
    KIND_OVER = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t             kind;
    logic                   last;
    logic [11:0]            w;
    logic signed [WV_W-1:0] wv;
    logic [VV_W-1:0]        sq;
  } item_t;

  typedef enum logic [3:0] {
    S_ACC,
    S_FIN,
    S_MUL_P1,
    S_MUL_P2,
    S_MUL_D,
    S_MUL_DC,
    S_DIV_MEAN,
    S_DIV_SD,
    S_SQRT_SD,
    S_DIV_SE,
    S_SQRT_SE,
    S_DONE
  } back_state_t;

endpackage

>>> rtl/wms_front.sv
// front end: classifies each transaction and forms its per-item products
module wms_front import wms_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  sample_t sample,
  output item_t   item
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]   count;
  logic [16:0]     mag;
  logic [33:0]     sq_full;
  logic signed [28:0] wv_full;

  always_comb begin
    mag = sample.sample_value[15] ?
          (17'd0 - {sample.sample_value[15], sample.sample_value}) :
          {1'b0, sample.sample_value};
    sq_full = {17'd0, mag} * {17'd0, mag};
    wv_full = $signed({1'b0, sample.sample_weight}) * sample.sample_value;
    item.last = sample.last_item;
    item.w    = sample.sample_weight;
    item.wv   = wv_full[WV_W-1:0];
    item.sq   = sq_full[VV_W-1:0];
    if (sample.value_missing) begin
      item.kind = KIND_SKIP;
    end else if (count == CW'(MAX_ITEMS)) begin
      item.kind = KIND_OVER;
    end else begin
      item.kind = KIND_ACC;
    end
  end

  // survivors seen so far in this run
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (sample.last_item) begin
        count <= '0;
      end else if (item.kind == KIND_ACC) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

>>> rtl/wms_fifo.sv
// short queue of classified items between front and back
module wms_fifo import wms_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wms_back.sv
// back end: accumulates sums and runs the end-of-run arithmetic sequencer
module wms_back import wms_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   head,
  input  logic    head_valid,
  output logic    head_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  back_state_t state, state_next;

  logic [SW_W-1:0]        sw;
  logic signed [SV_W-1:0] swv;
  logic [SQ_W-1:0]        swvv;
  logic [CW-1:0]          count;
  logic                   overflow;

  logic [N_W-1:0]  mul_a;
  logic [MB_W-1:0] mul_b;
  logic [N_W-1:0]  mul_acc;
  logic [N_W-1:0]  p1;
  logic [N_W-1:0]  n;
  logic [D_W-1:0]  dd;
  logic [D_W-1:0]  ddc;

  logic [D_W-1:0]  div_rem;
  logic [N_W-1:0]  div_num;
  logic [D_W-1:0]  div_d;
  logic [Q_W-1:0]  div_quo;
  logic [DC_W-1:0] div_cnt;

  logic [Q_W-1:0]  sq_x;
  logic [Q_W-1:0]  sq_res;
  logic [Q_W-1:0]  sq_bit;

  logic [15:0] mean;
  logic [15:0] sd;
  logic [15:0] se;
  status_t     status;
  logic        out_valid;
  result_t     out_data;

  logic [SV_W-1:0] mag;
  logic [42:0]     wsq;
  logic [D_W:0]    div_try;
  logic            div_ge;
  logic [D_W-1:0]  div_rem_next;
  logic [Q_W-1:0]  sq_sum;
  logic            sq_ge;
  logic [16:0]     mean_val;
  logic            mul_done;
  logic            load_out;
  status_t         status_now;

  always_comb begin
    mag    = swv[SV_W-1] ? (SV_W'(0) - swv) : swv;
    wsq    = {31'd0, head.w} * {12'd0, head.sq};
    div_try = {div_rem, div_num[N_W-1]};
    div_ge  = (div_try >= {1'b0, div_d});
    div_rem_next = div_ge ? D_W'(div_try - {1'b0, div_d}) : div_try[D_W-1:0];
    sq_sum = sq_res + sq_bit;
    sq_ge  = (sq_x >= sq_sum);
    mul_done = (mul_b == '0);
    mean_val = swv[SV_W-1] ?
               (17'd0 - div_quo[16:0] - {16'd0, (div_rem != '0)}) : div_quo[16:0];
    if (overflow) begin
      status_now = ST_OVER;
    end else if (count == '0) begin
      status_now = ST_NONE;
    end else if (sw == '0) begin
      status_now = ST_ZERO_W;
    end else begin
      status_now = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_ACC: begin
        head_pop = head_valid;
        if (head_valid && head.last) begin
          state_next = S_FIN;
        end
      end
      S_FIN:      state_next = (status_now == ST_OK) ? S_MUL_P1 : S_DONE;
      S_MUL_P1:   if (mul_done) state_next = S_MUL_P2;
      S_MUL_P2:   if (mul_done) state_next = S_MUL_D;
      S_MUL_D:    if (mul_done) state_next = S_MUL_DC;
      S_MUL_DC:   if (mul_done) state_next = S_DIV_MEAN;
      S_DIV_MEAN: if (div_cnt == '0) state_next = S_DIV_SD;
      S_DIV_SD:   if (div_cnt == '0) state_next = S_SQRT_SD;
      S_SQRT_SD:  if (sq_bit == '0) state_next = S_DIV_SE;
      S_DIV_SE:   if (div_cnt == '0) state_next = S_SQRT_SE;
      S_SQRT_SE:  if (sq_bit == '0) state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  // run accumulators
  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      sw       <= '0;
      swv      <= '0;
      swvv     <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (head_pop) begin
      if (head.kind == KIND_ACC) begin
        sw    <= sw + SW_W'(head.w);
        swv   <= swv + {{(SV_W - WV_W){head.wv[WV_W-1]}}, head.wv};
        swvv  <= swvv + {{(SQ_W - 43){1'b0}}, wsq};
        count <= count + 1'b1;
      end else if (head.kind == KIND_OVER) begin
        overflow <= 1'b1;
      end
    end
  end

  // shift-add multiplier, restoring divider and bitwise square root
  always_ff @(posedge clk) begin
    case (state)
      S_FIN: begin
        status <= status_now;
        mean   <= '0;
        sd     <= '0;
        se     <= '0;
        mul_a   <= {{(N_W - SQ_W){1'b0}}, swvv};
        mul_b   <= {{(MB_W - SW_W){1'b0}}, sw};
        mul_acc <= '0;
      end
      S_MUL_P1, S_MUL_P2, S_MUL_D, S_MUL_DC: begin
        if (!mul_done) begin
          mul_acc <= mul_acc + (mul_b[0] ? mul_a : '0);
          mul_a   <= {mul_a[N_W-2:0], 1'b0};
          mul_b   <= {1'b0, mul_b[MB_W-1:1]};
        end else begin
          mul_acc <= '0;
          case (state)
            S_MUL_P1: begin
              p1    <= mul_acc;
              mul_a <= {{(N_W - SV_W){1'b0}}, mag};
              mul_b <= mag;
            end
            S_MUL_P2: begin
              n     <= p1 - mul_acc;
              mul_a <= {{(N_W - SW_W){1'b0}}, sw};
              mul_b <= {{(MB_W - SW_W){1'b0}}, sw};
            end
            S_MUL_D: begin
              dd    <= mul_acc[D_W-1:0];
              mul_a <= mul_acc;
              mul_b <= {{(MB_W - CW){1'b0}}, count};
            end
            default: begin
              // mean divide: quotient magnitude fits 17 bits
              ddc     <= mul_acc[D_W-1:0];
              div_rem <= {{(D_W - SV_W + 17){1'b0}}, mag[SV_W-1:17]};
              div_num <= {mag[16:0], {(N_W - 17){1'b0}}};
              div_d   <= {{(D_W - SW_W){1'b0}}, sw};
              div_quo <= '0;
              div_cnt <= DC_W'(17);
            end
          endcase
        end
      end
      S_DIV_MEAN, S_DIV_SD, S_DIV_SE: begin
        if (div_cnt != '0) begin
          div_rem <= div_rem_next;
          div_num <= {div_num[N_W-2:0], 1'b0};
          div_quo <= {div_quo[Q_W-2:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
        end else if (state == S_DIV_MEAN) begin
          mean    <= mean_val[15:0];
          div_rem <= {{(D_W - N_W + Q_W){1'b0}}, n[N_W-1:Q_W]};
          div_num <= {n[Q_W-1:0], {(N_W - Q_W){1'b0}}};
          div_d   <= dd;
          div_quo <= '0;
          div_cnt <= DC_W'(Q_W);
        end else begin
          sq_x   <= div_quo;
          sq_res <= '0;
          sq_bit <= {2'b01, {(Q_W - 2){1'b0}}};
        end
      end
      S_SQRT_SD, S_SQRT_SE: begin
        if (sq_bit != '0) begin
          if (sq_ge) begin
            sq_x   <= sq_x - sq_sum;
            sq_res <= {1'b0, sq_res[Q_W-1:1]} + sq_bit;
          end else begin
            sq_res <= {1'b0, sq_res[Q_W-1:1]};
          end
          sq_bit <= {2'b00, sq_bit[Q_W-1:2]};
        end else if (state == S_SQRT_SD) begin
          sd      <= sq_res[15:0];
          div_rem <= {{(D_W - N_W + Q_W){1'b0}}, n[N_W-1:Q_W]};
          div_num <= {n[Q_W-1:0], {(N_W - Q_W){1'b0}}};
          div_d   <= ddc;
          div_quo <= '0;
          div_cnt <= DC_W'(Q_W);
        end else begin
          se <= sq_res[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // single result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.weighted_mean  <= mean;
      out_data.weighted_sd    <= sd;
      out_data.standard_error <= se;
      out_data.result_status  <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign result = out_data;
  assign empty  = !out_valid;

endmodule

>>> rtl/weighted_mean_sd_se_top.sv
// top level of the weighted mean, standard deviation and standard error block
// Weighted mean / sd / se of a run of samples. Each push transaction carries one
// (value, weight, missing, last) sample; samples stream in at one per clock while
// the run is open, since each costs only a small product in the front end and one
// multiply-accumulate in the back end. A classified-item queue of four entries
// sits between them. The transaction marked last closes the run: the back end then
// works through a shared shift-add multiplier (four products, one operand bit
// per cycle), a restoring divider (17 steps for the mean, 32 for each variance
// quotient) and a bitwise square root (16 steps each), and the queue fills and
// full rises until it is done. Error runs (too many items, no surviving value,
// zero weight) skip the arithmetic and go from the closing state straight to
// the done state. One result waits in an output register until popped; the next
// run's samples are accepted meanwhile.
module weighted_mean_sd_se_top import wms_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  sample_t sample,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic  accept;
  item_t front_item;
  item_t head;
  logic  head_valid;
  logic  head_pop;

  // input transaction lands in the queue in the same cycle
  assign accept = push && !full;

  wms_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .item   (front_item)
  );

  wms_fifo #(.DEPTH(4)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_item (front_item),
    .full    (full),
    .rd      (head_pop),
    .rd_item (head),
    .valid   (head_valid)
  );

  // back end drains the queue and owns the result register
  wms_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
